[hw/rtl/event_time_editor_sorted_store_unit_macros.svh]
// Assertion macros shared by the event-time editor RTL.
`ifndef EVENT_TIME_EDITOR_SORTED_STORE_UNIT_MACROS_SVH
`define EVENT_TIME_EDITOR_SORTED_STORE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ETT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ETT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/ett_pkg.sv]
// Types, constants and the sort-key helper function for the event-time editor.
`timescale 1ns / 1ps

package ett_pkg;

    // Key codes carried on the input beat.
    typedef enum logic [2:0] {
        REQ_NONE  = 3'd0,
        REQ_INC   = 3'd1,
        REQ_NEXT  = 3'd2,
        REQ_STORE = 3'd3,
        REQ_EXIT  = 3'd4
    } req_t;

    // Result of a store request.
    typedef enum logic [1:0] {
        STS_NONE      = 2'd0,
        STS_INSERTED  = 2'd1,
        STS_DUPLICATE = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } state_t;

    // Field selection codes.
    localparam logic [1:0] FIELD_HOUR   = 2'd0;
    localparam logic [1:0] FIELD_MINUTE = 2'd1;
    localparam logic [1:0] FIELD_PM     = 2'd2;

    localparam logic [3:0] HOUR_MAX   = 4'd12;
    localparam logic [3:0] HOUR_FIRST = 4'd1;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    // One table entry: half of day, hour, minute.
    typedef struct packed {
        logic       pm;
        logic [3:0] hour;
        logic [5:0] minute;
    } entry_t;

    typedef logic [10:0] key_t;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic   compare_en;
        logic   write_en;
        entry_t new_entry;
        key_t   new_key;
    } cell_cmd_t;

    // Per-cell comparison flags.
    typedef struct packed {
        logic lt;
        logic eq;
        logic boundary;
    } cell_flags_t;

    // Ordering key: AM before PM, then hour mod 12, then minute.
    function automatic key_t sort_key(entry_t e);
        logic [3:0] h;
        h = (e.hour >= HOUR_MAX) ? (e.hour - HOUR_MAX) : e.hour;
        return {e.pm, h, e.minute};
    endfunction

endpackage

[hw/rtl/ett_cell.sv]
// One slot of the sorted table: holds an entry, compares and shifts right.
`timescale 1ns / 1ps

module ett_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ett_pkg::cell_cmd_t  cmd,
    input  logic                occupied,
    input  logic                left_lt,
    input  ett_pkg::entry_t     left_entry,
    output ett_pkg::entry_t     entry,
    output ett_pkg::cell_flags_t flags
);
    import ett_pkg::*;

    entry_t entry_reg;
    logic   lt_reg;
    logic   eq_reg;
    key_t   my_key;
    logic   boundary;

    assign my_key = sort_key(entry_reg);

    // The insertion point is the first slot whose key is not below the new one.
    assign boundary = left_lt && !lt_reg;

    // Compare flags are captured once per beat and held for the update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (cmd.compare_en)
        begin
            lt_reg <= occupied && (my_key < cmd.new_key);
            eq_reg <= occupied && (my_key == cmd.new_key);
        end
    end

    // Slots at the insertion point take the new entry, later ones the left neighbor.
    always_ff @(posedge clk)
    begin
        if (cmd.write_en && !lt_reg)
        begin
            entry_reg <= boundary ? cmd.new_entry : left_entry;
        end
    end

    assign entry          = entry_reg;
    assign flags.lt       = lt_reg;
    assign flags.eq       = eq_reg;
    assign flags.boundary = boundary;

endmodule

[hw/rtl/ett_editor.sv]
// Edit-time registers: load from the current time and apply key events.
`timescale 1ns / 1ps

module ett_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       apply,
    input  logic [2:0] req,
    input  logic [3:0] cur_hour,
    input  logic [5:0] cur_minute,
    input  logic       cur_pm,
    output logic [3:0] edit_hour,
    output logic [5:0] edit_minute,
    output logic       edit_pm,
    output logic [1:0] selected_field
);
    import ett_pkg::*;

    logic [3:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic       pm_reg, pm_next;
    logic [1:0] sel_reg, sel_next;
    logic       loaded_reg, loaded_next;

    logic [3:0] base_hour;
    logic [5:0] base_minute;
    logic       base_pm;
    logic [4:0] hour_inc;
    logic [6:0] minute_inc;
    logic [2:0] sel_inc;

    // Time the key acts on: the current time until it has been loaded.
    assign base_hour   = loaded_reg ? hour_reg   : cur_hour;
    assign base_minute = loaded_reg ? minute_reg : cur_minute;
    assign base_pm     = loaded_reg ? pm_reg     : cur_pm;

    assign hour_inc   = {1'b0, base_hour} + 5'd1;
    assign minute_inc = {1'b0, base_minute} + 7'd1;
    assign sel_inc    = {1'b0, sel_reg} + 3'd1;

    // Apply one key event.
    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        pm_next     = pm_reg;
        sel_next    = sel_reg;
        loaded_next = loaded_reg;
        if (apply)
        begin
            hour_next   = base_hour;
            minute_next = base_minute;
            pm_next     = base_pm;
            loaded_next = 1'b1;
            case (req)
                REQ_INC:
                begin
                    case (sel_reg)
                        FIELD_HOUR:
                        begin
                            hour_next = (hour_inc > {1'b0, HOUR_MAX}) ? HOUR_FIRST
                                                                      : hour_inc[3:0];
                        end
                        FIELD_MINUTE:
                        begin
                            minute_next = (minute_inc > {1'b0, MINUTE_MAX}) ? 6'd0
                                                                           : minute_inc[5:0];
                        end
                        FIELD_PM:
                        begin
                            pm_next = !base_pm;
                        end
                        default:
                        begin
                            pm_next = base_pm;
                        end
                    endcase
                end
                REQ_NEXT:
                begin
                    sel_next = (sel_inc > {1'b0, FIELD_PM}) ? FIELD_HOUR : sel_inc[1:0];
                end
                REQ_EXIT:
                begin
                    pm_next     = 1'b0;
                    loaded_next = 1'b0;
                end
                default:
                begin
                    sel_next = sel_reg;
                end
            endcase
        end
    end

    // Editor state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg   <= '0;
            minute_reg <= '0;
            pm_reg     <= 1'b0;
            sel_reg    <= FIELD_HOUR;
            loaded_reg <= 1'b0;
        end
        else
        begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            pm_reg     <= pm_next;
            sel_reg    <= sel_next;
            loaded_reg <= loaded_next;
        end
    end

    assign edit_hour      = hour_reg;
    assign edit_minute    = minute_reg;
    assign edit_pm        = pm_reg;
    assign selected_field = sel_reg;

endmodule

[hw/rtl/event_time_editor_sorted_store_unit.sv]
// Top level of the event-time editor with a sorted event table in a cell chain.
//
//  Channel | Dir | Handshake         | Content
//  --------+-----+-------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tuser: key code; tdata: current time
//  m_*     | out | m_tvalid/m_tready | tdata: edit time, selection, count, status
//
// Each beat passes through accept, compare in every cell, then update.
// The compare step is one parallel compare per cell, so the sequence is the same for any
// CAPACITY. A result waits in the output register while the next beat is accepted;
// the update step waits only while that register is still held by the sink.
// Reset clears the control state; table slots are written before they are read,
// so no clearing pass follows reset.
`timescale 1ns / 1ps

module event_time_editor_sorted_store_unit #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] cur_hour, [9:4] cur_minute, [10] cur_pm, [15:11] zero
    input  logic [15:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] edit_hour_out, [9:4] edit_minute_out, [10] edit_pm_out,
    // [12:11] selected_field, [17:13] stored_count, [19:18] store_status,
    // [23:20] store_position, [24] exited, [31:25] zero
    output logic [31:0] m_tdata
);
    import ett_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          store_reg, exit_reg;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_data_reg;

    logic          accept;
    logic          compare_en;
    logic          advance;
    logic          out_free;
    logic          dup;
    logic          full;
    logic          write_en;
    status_t       status;
    logic [PW-1:0] pos_w;
    logic [3:0]    pos_out;

    logic [3:0]    edit_hour;
    logic [5:0]    edit_minute;
    logic          edit_pm;
    logic [1:0]    selected_field;

    cell_cmd_t     cmd;
    entry_t        entry_w [CAPACITY];
    cell_flags_t   flags_w [CAPACITY];
    logic [CAPACITY-1:0] lt_vec, eq_vec, boundary_vec;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Edit-time registers.
    ett_editor u_editor (
        .clk            (clk),
        .rst_n          (rst_n),
        .apply          (accept),
        .req            (s_tuser),
        .cur_hour       (s_tdata[3:0]),
        .cur_minute     (s_tdata[9:4]),
        .cur_pm         (s_tdata[10]),
        .edit_hour      (edit_hour),
        .edit_minute    (edit_minute),
        .edit_pm        (edit_pm),
        .selected_field (selected_field)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready   = 1'b0;
        compare_en = 1'b0;
        advance    = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_tready   = 1'b1;
            ST_COMPARE: compare_en = 1'b1;
            ST_UPDATE:  advance    = out_free;
            default:    s_tready   = 1'b0;
        endcase
    end

    // Command broadcast to the chain.
    assign cmd.compare_en       = compare_en;
    assign cmd.write_en         = write_en;
    assign cmd.new_entry.pm     = edit_pm;
    assign cmd.new_entry.hour   = edit_hour;
    assign cmd.new_entry.minute = edit_minute;
    assign cmd.new_key          = sort_key(cmd.new_entry);

    // Chain of table cells; each one shifts from its left neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_chain
        logic   occupied;
        logic   left_lt;
        entry_t left_entry;

        assign occupied = count_reg > CW'(i);
        if (i == 0)
        begin : g_head
            assign left_lt    = 1'b1;
            assign left_entry = cmd.new_entry;
        end
        else
        begin : g_body
            assign left_lt    = flags_w[i-1].lt;
            assign left_entry = entry_w[i-1];
        end

        ett_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .occupied   (occupied),
            .left_lt    (left_lt),
            .left_entry (left_entry),
            .entry      (entry_w[i]),
            .flags      (flags_w[i])
        );

        assign lt_vec[i]       = flags_w[i].lt;
        assign eq_vec[i]       = flags_w[i].eq;
        assign boundary_vec[i] = flags_w[i].boundary;
    end

    // Insertion or match position from the one-hot boundary flags.
    always_comb
    begin
        pos_w = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (boundary_vec[i])
            begin
                pos_w = pos_w | PW'(i);
            end
        end
    end

    // Store outcome.
    assign dup      = |eq_vec;
    assign full     = count_reg >= CW'(CAPACITY);
    assign write_en = advance && store_reg && !dup && !full;

    always_comb
    begin
        status  = STS_NONE;
        pos_out = 4'd0;
        if (store_reg)
        begin
            if (dup)
            begin
                status  = STS_DUPLICATE;
                pos_out = 4'(pos_w);
            end
            else if (full)
            begin
                status = STS_FULL;
            end
            else
            begin
                status  = STS_INSERTED;
                pos_out = 4'(pos_w);
            end
        end
    end

    assign count_next     = write_en ? (count_reg + CW'(1)) : count_reg;
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            store_reg     <= 1'b0;
            exit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                store_reg <= (s_tuser == REQ_STORE);
                exit_reg  <= (s_tuser == REQ_EXIT);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {7'd0, exit_reg, pos_out, status, 5'(count_next),
                             selected_field, edit_pm, edit_minute, edit_hour};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`include "event_time_editor_sorted_store_unit_macros.svh"

    `ETT_ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `ETT_ASSERT_NEXT(a_count_step, write_en, count_reg == ($past(count_reg) + CW'(1)))
    `ETT_ASSERT_IMPLIES(a_one_slot, state_reg == ST_UPDATE, $onehot0(boundary_vec))
    `ETT_ASSERT_IMPLIES(a_flag_excl, state_reg == ST_UPDATE, (lt_vec & eq_vec) == '0)

endmodule

[verif/tb.sv]
// Self-checking testbench for the event-time editor with its sorted event table.
`timescale 1ns / 1ps

module tb;
    import ett_pkg::*;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int ROWS = 24;

    // Result beat, highest field first, as packed on m_tdata[24:0].
    typedef struct packed {
        logic       exited;
        logic [3:0] position;
        status_t    status;
        logic [4:0] count;
        logic [1:0] field;
        logic       pm;
        logic [5:0] minute;
        logic [3:0] hour;
    } editor_result_t;

    // One key beat, with an optional literal expectation.
    typedef struct {
        logic [2:0]     code;
        logic [3:0]     hour;
        logic [5:0]     minute;
        logic           pm;
        bit             typed;
        editor_result_t want;
    } key_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Editor state as the checker sees it.
    logic [3:0] ed_hour = '0;
    logic [5:0] ed_minute = '0;
    logic       ed_pm = 1'b0;
    logic [1:0] ed_field = '0;
    logic       ed_loaded = 1'b0;
    logic [4:0] ed_count = '0;
    entry_t     ed_table [SLOTS];

    editor_result_t pending_results [$];
    key_row_t       directed_keys [ROWS];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stall_served = 0;
    int stall_left = 0;
    int err_count = 0;
    int cycle_count = 0;

    event_time_editor_sorted_store_unit #(
        .CAPACITY(SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    // Ordering key: AM before PM, then hour mod 12, then minute.
    function automatic logic [10:0] order_key(logic pm, logic [3:0] hour, logic [5:0] minute);
        logic [3:0] h;
        h = hour % 4'd12;
        return {pm, h, minute};
    endfunction

    // Applies one key to the editor state and returns the beat it should produce.
    function automatic editor_result_t editor_step(logic [2:0] code, logic [3:0] cur_hour,
                                                   logic [5:0] cur_minute, logic cur_pm);
        editor_result_t r;
        logic [10:0]    new_key;
        logic [10:0]    slot_key;
        int             slot;
        bit             matched;
        bit             stopped;
        r = '0;
        slot = 0;
        matched = 0;
        stopped = 0;

        // Any key, even none or exit, first loads the current time when unloaded.
        if (!ed_loaded) begin
            ed_hour = cur_hour;
            ed_minute = cur_minute;
            ed_pm = cur_pm;
            ed_loaded = 1'b1;
        end

        case (code)
            REQ_INC: begin
                if (ed_field == FIELD_HOUR)
                    ed_hour = (int'(ed_hour) + 1 > int'(HOUR_MAX)) ? HOUR_FIRST : ed_hour + 4'd1;
                else if (ed_field == FIELD_MINUTE)
                    ed_minute = (int'(ed_minute) + 1 > int'(MINUTE_MAX)) ? 6'd0
                                                                         : ed_minute + 6'd1;
                else if (ed_field == FIELD_PM)
                    ed_pm = ~ed_pm;
            end
            REQ_NEXT: begin
                ed_field = (int'(ed_field) + 1 > int'(FIELD_PM)) ? FIELD_HOUR : ed_field + 2'd1;
            end
            REQ_STORE: begin
                new_key = order_key(ed_pm, ed_hour, ed_minute);
                // Walk the sorted entries to the first one not below the new time.
                for (int i = 0; i < SLOTS; i++) begin
                    if (!stopped && i < int'(ed_count)) begin
                        slot_key = order_key(ed_table[i].pm, ed_table[i].hour,
                                             ed_table[i].minute);
                        if (slot_key == new_key) begin
                            matched = 1;
                            stopped = 1;
                        end else if (slot_key > new_key) begin
                            stopped = 1;
                        end else begin
                            slot++;
                        end
                    end
                end
                if (matched) begin
                    r.status = STS_DUPLICATE;
                    r.position = 4'(slot);
                end else if (int'(ed_count) >= SLOTS) begin
                    r.status = STS_FULL;
                end else begin
                    for (int j = SLOTS - 1; j > 0; j--)
                        if (j > slot && j <= int'(ed_count))
                            ed_table[j] = ed_table[j - 1];
                    ed_table[slot] = '{pm: ed_pm, hour: ed_hour, minute: ed_minute};
                    ed_count = ed_count + 5'd1;
                    r.status = STS_INSERTED;
                    r.position = 4'(slot);
                end
            end
            REQ_EXIT: begin
                ed_pm = 1'b0;
                ed_loaded = 1'b0;
                r.exited = 1'b1;
            end
            default: ;
        endcase

        r.hour = ed_hour;
        r.minute = ed_minute;
        r.pm = ed_pm;
        r.field = ed_field;
        r.count = ed_count;
        return r;
    endfunction

    function automatic editor_result_t result_lit(logic [3:0] hour, logic [5:0] minute,
                                                  logic pm, logic [1:0] field,
                                                  logic [4:0] count, status_t status,
                                                  logic [3:0] position, logic exited);
        editor_result_t r;
        r = '{exited: exited, position: position, status: status, count: count,
              field: field, pm: pm, minute: minute, hour: hour};
        return r;
    endfunction

    function automatic key_row_t plain(logic [2:0] code, logic [3:0] hour,
                                       logic [5:0] minute, logic pm);
        key_row_t k;
        k.code = code;
        k.hour = hour;
        k.minute = minute;
        k.pm = pm;
        k.typed = 0;
        k.want = '0;
        return k;
    endfunction

    function automatic key_row_t checked(logic [2:0] code, logic [3:0] hour, logic [5:0] minute,
                                         logic pm, editor_result_t want);
        key_row_t k;
        k = plain(code, hour, minute, pm);
        k.typed = 1;
        k.want = want;
        return k;
    endfunction

    function automatic key_row_t random_key(logic [2:0] code);
        return plain(code, 4'($urandom_range(15)), 6'($urandom_range(63)),
                     1'($urandom_range(1)));
    endfunction

    // Offers one key beat, idling first at random, and records its expected result.
    task automatic send_key(input key_row_t k);
        editor_result_t expected;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k.code;
        s_tdata <= {5'd0, k.pm, k.minute, k.hour};
        do
            @(posedge clk);
        while (!s_tready);
        expected = editor_step(k.code, k.hour, k.minute, k.pm);
        if (k.typed)
            expected = k.want;
        pending_results.push_back(expected);
    endtask

    // Mostly whole edit sessions (exit, a few edits, store), the rest single random keys.
    task automatic send_random(input int item_total);
        int sent;
        int edits;
        sent = 0;
        while (sent < item_total) begin
            if ($urandom_range(99) < 70) begin
                send_key(random_key(REQ_EXIT));
                edits = $urandom_range(5);
                repeat (edits)
                    send_key(random_key($urandom_range(1) ? REQ_INC : REQ_NEXT));
                send_key(random_key(REQ_STORE));
                sent += edits + 2;
            end else begin
                send_key(random_key(3'($urandom_range(7))));
                sent++;
            end
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Sink side: check each result beat, then pick the ready for the next edge.
    always @(posedge clk) begin
        editor_result_t got;
        editor_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = editor_result_t'(m_tdata[24:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, got %h", $time, m_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("edit_hour_out", want.hour, got.hour);
                report_field("edit_minute_out", want.minute, got.minute);
                report_field("edit_pm_out", want.pm, got.pm);
                report_field("selected_field", want.field, got.field);
                report_field("stored_count", want.count, got.count);
                report_field("store_status", want.status, got.status);
                report_field("store_position", want.position, got.position);
                report_field("exited", want.exited, got.exited);
            end
        end
        if (stall_requests != stall_served) begin
            stall_served = stall_requests;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        // Directed keys: wraps, duplicates, loads on no key and exit, unused codes,
        // hours past 12 and the 12 o'clock / 0 o'clock equivalence.
        directed_keys[0]  = checked(REQ_NONE, 4'd12, 6'd59, 1'b1,
            result_lit(4'd12, 6'd59, 1'b1, FIELD_HOUR, 5'd0, STS_NONE, 4'd0, 1'b0));
        directed_keys[1]  = checked(REQ_INC, 4'd0, 6'd0, 1'b0,
            result_lit(4'd1, 6'd59, 1'b1, FIELD_HOUR, 5'd0, STS_NONE, 4'd0, 1'b0));
        directed_keys[2]  = checked(REQ_NEXT, 4'd5, 6'd5, 1'b0,
            result_lit(4'd1, 6'd59, 1'b1, FIELD_MINUTE, 5'd0, STS_NONE, 4'd0, 1'b0));
        directed_keys[3]  = checked(REQ_INC, 4'd0, 6'd0, 1'b0,
            result_lit(4'd1, 6'd0, 1'b1, FIELD_MINUTE, 5'd0, STS_NONE, 4'd0, 1'b0));
        directed_keys[4]  = checked(REQ_STORE, 4'd0, 6'd0, 1'b0,
            result_lit(4'd1, 6'd0, 1'b1, FIELD_MINUTE, 5'd1, STS_INSERTED, 4'd0, 1'b0));
        directed_keys[5]  = checked(REQ_STORE, 4'd0, 6'd0, 1'b0,
            result_lit(4'd1, 6'd0, 1'b1, FIELD_MINUTE, 5'd1, STS_DUPLICATE, 4'd0, 1'b0));
        directed_keys[6]  = checked(REQ_EXIT, 4'd9, 6'd9, 1'b1,
            result_lit(4'd1, 6'd0, 1'b0, FIELD_MINUTE, 5'd1, STS_NONE, 4'd0, 1'b1));
        directed_keys[7]  = checked(3'd5, 4'd15, 6'd63, 1'b0,
            result_lit(4'd15, 6'd63, 1'b0, FIELD_MINUTE, 5'd1, STS_NONE, 4'd0, 1'b0));
        directed_keys[8]  = checked(REQ_INC, 4'd0, 6'd0, 1'b0,
            result_lit(4'd15, 6'd0, 1'b0, FIELD_MINUTE, 5'd1, STS_NONE, 4'd0, 1'b0));
        directed_keys[9]  = plain(REQ_NEXT, 4'd0, 6'd0, 1'b0);
        directed_keys[10] = plain(REQ_NEXT, 4'd0, 6'd0, 1'b0);
        directed_keys[11] = plain(REQ_INC, 4'd0, 6'd0, 1'b0);
        directed_keys[12] = plain(REQ_STORE, 4'd0, 6'd0, 1'b0);
        directed_keys[13] = plain(REQ_EXIT, 4'd0, 6'd0, 1'b0);
        directed_keys[14] = plain(3'd6, 4'd0, 6'd0, 1'b1);
        directed_keys[15] = plain(REQ_STORE, 4'd7, 6'd7, 1'b0);
        directed_keys[16] = plain(REQ_EXIT, 4'd0, 6'd0, 1'b0);
        directed_keys[17] = plain(REQ_EXIT, 4'd12, 6'd30, 1'b1);
        directed_keys[18] = plain(3'd7, 4'd12, 6'd0, 1'b1);
        directed_keys[19] = plain(REQ_STORE, 4'd0, 6'd0, 1'b0);
        directed_keys[20] = plain(REQ_NEXT, 4'd0, 6'd0, 1'b0);
        directed_keys[21] = plain(REQ_NEXT, 4'd0, 6'd0, 1'b0);
        directed_keys[22] = plain(REQ_INC, 4'd0, 6'd0, 1'b0);
        directed_keys[23] = plain(REQ_STORE, 4'd0, 6'd0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slow sink first, with the directed keys.
        send_idle_pct = 19;
        recv_idle_pct = 84;
        for (int i = 0; i < ROWS; i++)
            send_key(directed_keys[i]);
        send_random(360);

        // Slow source.
        send_idle_pct = 84;
        recv_idle_pct = 19;
        send_random(360);

        // Full rate, opening with a long sink stall so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_requests++;
        send_random(380);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_count == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[event_time_editor_sorted_store_unit.f]
+incdir+hw/rtl
hw/rtl/ett_pkg.sv
hw/rtl/ett_cell.sv
hw/rtl/ett_editor.sv
hw/rtl/event_time_editor_sorted_store_unit.sv
verif/tb.sv
